// ===== rtl/core/bu_pkg.sv =====
// bu_pkg: shared constants and types for the bilinear upscaler.
// This package has no dependencies. Every module in rtl/core imports it.
package bu_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int FRAC_BITS = 16;
  localparam int MAX_SCALE = 64;

  localparam int COORD_W = 14;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int SCALE_W = 7;
  localparam int REG_IDX_W = 2;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int AXW    = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
  localparam int SZ_W   = AXW + 1;
  localparam int DIM_W  = SZ_W + SCALE_W;
  localparam int DIV_IW = COORD_W + AXW;
  localparam int QW     = FRAC_BITS + AXW;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int HB_W   = PIX_W + W_W;
  localparam int SUM_W  = HB_W + W_W;
  localparam int BANK_AW = (ROW_AW - 1) + (COL_AW - 1);
  localparam int IN_DATA_W = ((2 * COORD_W + PIX_W + 7) / 8) * 8;

  localparam logic [W_W-1:0] ONE = W_W'(1) << FRAC_BITS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_SCALE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              v;
    logic              kind;
    logic              in_range;
    logic              wr_ok;
    logic [ROW_AW-1:0] lrow;
    logic [COL_AW-1:0] lcol;
    logic [PIX_W-1:0]  pix;
  } side_t;

endpackage

// ===== rtl/core/bu_ram.sv =====
// bu_ram: one bank of the source image store, one write and one read port.
// Depends on bu_pkg for widths. Read data is registered.
module bu_ram
  import bu_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [PIX_W-1:0]   wdata,
  input  logic [BANK_AW-1:0] raddr,
  output logic [PIX_W-1:0]   rdata
);

  logic [PIX_W-1:0] mem [1 << BANK_AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bu_divider.sv =====
// bu_divider: pipelined restoring divider, one quotient bit per stage.
// Depends on bu_pkg. Computes (num << FRAC_BITS) / den.
module bu_divider
  import bu_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [DIV_IW-1:0] num,
  input  logic [DIM_W-1:0]  den,
  output logic [QW-1:0]     quot
);

  logic [DIM_W-1:0] rem [QW+1];
  logic [QW-1:0]    nb  [QW+1];
  logic [QW-1:0]    q   [QW+1];
  logic [DIM_W-1:0] dv  [QW+1];

  // quotient fits QW bits, so the top part of the numerator is below den
  assign rem[0] = DIM_W'(num[DIV_IW-1:AXW]);
  assign nb[0]  = {num[AXW-1:0], {FRAC_BITS{1'b0}}};
  assign q[0]   = '0;
  assign dv[0]  = den;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DIM_W:0]   trial;
    logic             ge;
    logic [DIM_W:0]   diff;
    logic [DIM_W-1:0] rem_r;
    logic [QW-1:0]    nb_r;
    logic [QW-1:0]    q_r;
    logic [DIM_W-1:0] dv_r;

    assign trial = {rem[i], nb[i][QW-1]};
    assign ge    = trial >= {1'b0, dv[i]};
    assign diff  = trial - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        nb_r  <= {nb[i][QW-2:0], 1'b0};
        q_r   <= {q[i][QW-2:0], ge};
        dv_r  <= dv[i];
      end
    end

    assign rem[i+1] = rem_r;
    assign nb[i+1]  = nb_r;
    assign q[i+1]   = q_r;
    assign dv[i+1]  = dv_r;
  end

  assign quot = q[QW];

endmodule

// ===== rtl/core/bu_blend.sv =====
// bu_blend: two-stage bilinear blend, horizontal pass then vertical pass.
// Depends on bu_pkg.
module bu_blend
  import bu_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [PIX_W-1:0] p00,
  input  logic [PIX_W-1:0] p01,
  input  logic [PIX_W-1:0] p10,
  input  logic [PIX_W-1:0] p11,
  input  logic [W_W-1:0]   t,
  input  logic [W_W-1:0]   u,
  output logic [SUM_W-1:0] sum
);

  logic [HB_W-1:0] top_r;
  logic [HB_W-1:0] bot_r;
  logic [W_W-1:0]  u_r;
  logic [W_W-1:0]  omt;
  logic [W_W-1:0]  omu;

  assign omt = ONE - t;
  assign omu = ONE - u_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      top_r <= HB_W'(p00) * HB_W'(omt) + HB_W'(p01) * HB_W'(t);
      bot_r <= HB_W'(p10) * HB_W'(omt) + HB_W'(p11) * HB_W'(t);
      u_r   <= u;
      sum   <= SUM_W'(top_r) * SUM_W'(omu) + SUM_W'(bot_r) * SUM_W'(u_r);
    end
  end

endmodule

// ===== rtl/core/bilinear_upscaler.sv =====
// bilinear_upscaler: top level, source image store and bilinear query pipeline.
// Depends on bu_pkg, bu_divider, bu_blend and bu_ram.
//
//   channel  | handshake          | contents
//   s_       | s_tvalid/s_tready  | tdata: row, col, pixel_in; tuser: kind
//   m_       | m_tvalid/m_tready  | tdata: pixel_out; tuser: in_range
//   cfg_     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained while m_ is not stalled. The coordinate
// dividers resolve one bit per stage. Loads write the store at the read
// stage, so order against queries is kept. A stall on m_ freezes every
// stage; s_tready follows it. Reset clears valid bits and returns the
// configuration to its defaults; the store has no clearing pass.
module bilinear_upscaler
  import bu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // row[13:0], col[27:14], pixel_in[35:28]
  input  logic                 s_tuser,   // kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [PIX_W-1:0]     m_tdata,   // pixel_out[7:0]
  output logic                 m_tuser,   // in_range
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]   rows_cfg;
  logic [CFG_W-1:0]   cols_cfg;
  logic [SCALE_W-1:0] scale_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg  <= CFG_W'(256);
      cols_cfg  <= CFG_W'(256);
      scale_cfg <= SCALE_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROWS:  rows_cfg  <= cfg_data;
        REG_COLS:  cols_cfg  <= cfg_data;
        REG_SCALE: scale_cfg <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SZ_W-1:0] clamp_sz(logic [CFG_W-1:0] v, int maxv);
    logic [SZ_W-1:0] r;
    if (v < CFG_W'(2)) r = SZ_W'(2);
    else if (int'(v) > maxv) r = SZ_W'(maxv);
    else r = SZ_W'(v);
    return r;
  endfunction

  logic [SZ_W-1:0]    sr_c, sc_c;
  logic [SCALE_W-1:0] k_c;

  always_comb begin
    sr_c = clamp_sz(rows_cfg, MAX_ROWS);
    sc_c = clamp_sz(cols_cfg, MAX_COLS);
    if (scale_cfg == '0) k_c = SCALE_W'(1);
    else if (scale_cfg > SCALE_W'(MAX_SCALE)) k_c = SCALE_W'(MAX_SCALE);
    else k_c = scale_cfg;
  end

  // derived sizes, refreshed every cycle from static configuration
  logic [DIM_W-1:0] dr, dc, drm1, dcm1;
  logic [AXW-1:0]   srm1, scm1, srm2, scm2;

  always_ff @(posedge clk) begin
    dr   <= DIM_W'(sr_c) * DIM_W'(k_c);
    dc   <= DIM_W'(sc_c) * DIM_W'(k_c);
    drm1 <= DIM_W'(sr_c) * DIM_W'(k_c) - DIM_W'(1);
    dcm1 <= DIM_W'(sc_c) * DIM_W'(k_c) - DIM_W'(1);
    srm1 <= AXW'(sr_c - SZ_W'(1));
    scm1 <= AXW'(sc_c - SZ_W'(1));
    srm2 <= AXW'(sr_c - SZ_W'(2));
    scm2 <= AXW'(sc_c - SZ_W'(2));
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input register
  logic               v0, kind0;
  logic [COORD_W-1:0] row0, col0;
  logic [PIX_W-1:0]   pix0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind0 <= s_tuser;
      row0  <= s_tdata[COORD_W-1:0];
      col0  <= s_tdata[2*COORD_W-1:COORD_W];
      pix0  <= s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
    end
  end

  // range check, numerators, and sideband delay line across the dividers
  side_t             dl [QW+1];
  logic [DIV_IW-1:0] numr1, numc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QW; i++) begin
        dl[i].v <= 1'b0;
      end
    end else if (adv) begin
      numr1 <= DIV_IW'(row0) * DIV_IW'(srm1);
      numc1 <= DIV_IW'(col0) * DIV_IW'(scm1);
      dl[0] <= '{v:        v0,
                 kind:     kind0,
                 in_range: (DIM_W'(row0) < dr) && (DIM_W'(col0) < dc),
                 wr_ok:    (row0 < COORD_W'(MAX_ROWS)) && (col0 < COORD_W'(MAX_COLS)),
                 lrow:     row0[ROW_AW-1:0],
                 lcol:     col0[COL_AW-1:0],
                 pix:      pix0};
      for (int i = 1; i <= QW; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  logic [QW-1:0] posr, posc;

  bu_divider u_div_row (.clk(clk), .adv(adv), .num(numr1), .den(drm1), .quot(posr));
  bu_divider u_div_col (.clk(clk), .adv(adv), .num(numc1), .den(dcm1), .quot(posc));

  // base clamp and fractions
  side_t          s2;
  logic [AXW-1:0] h2, w2;
  logic [W_W-1:0] u2, t2;
  logic [AXW-1:0] hb, wb;

  always_comb begin
    hb = posr[QW-1:FRAC_BITS];
    wb = posc[QW-1:FRAC_BITS];
    if (hb > srm2) hb = srm2;
    if (wb > scm2) wb = scm2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.v <= 1'b0;
    end else if (adv) begin
      s2 <= dl[QW];
      h2 <= hb;
      w2 <= wb;
      u2 <= W_W'(posr - {hb, {FRAC_BITS{1'b0}}});
      t2 <= W_W'(posc - {wb, {FRAC_BITS{1'b0}}});
    end
  end

  // store: four banks split by row and column parity
  logic [AXW-1:0]     h2p1, w2p1;
  logic [ROW_AW-1:0]  rsel [2];
  logic [COL_AW-1:0]  csel [2];
  logic [PIX_W-1:0]   rd   [4];

  assign h2p1 = h2 + AXW'(1);
  assign w2p1 = w2 + AXW'(1);

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rsel[p] = ROW_AW'((h2[0] == p[0]) ? h2 : h2p1);
      csel[p] = COL_AW'((w2[0] == p[0]) ? w2 : w2p1);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic we_b;
    assign we_b = s2.v && !s2.kind && s2.wr_ok &&
                  (s2.lrow[0] == b[1]) && (s2.lcol[0] == b[0]);
    bu_ram u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (we_b),
      .waddr ({s2.lrow[ROW_AW-1:1], s2.lcol[COL_AW-1:1]}),
      .wdata (s2.pix),
      .raddr ({rsel[b/2][ROW_AW-1:1], csel[b%2][COL_AW-1:1]}),
      .rdata (rd[b])
    );
  end

  side_t          s3;
  logic [W_W-1:0] u3, t3;
  logic           h0_3, w0_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.v <= 1'b0;
    end else if (adv) begin
      s3   <= s2;
      u3   <= u2;
      t3   <= t2;
      h0_3 <= h2[0];
      w0_3 <= w2[0];
    end
  end

  logic [SUM_W-1:0] sum5;

  bu_blend u_blend (
    .clk (clk),
    .adv (adv),
    .p00 (rd[{h0_3, w0_3}]),
    .p01 (rd[{h0_3, ~w0_3}]),
    .p10 (rd[{~h0_3, w0_3}]),
    .p11 (rd[{~h0_3, ~w0_3}]),
    .t   (t3),
    .u   (u3),
    .sum (sum5)
  );

  side_t s4, s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.v <= 1'b0;
      s5.v <= 1'b0;
    end else if (adv) begin
      s4 <= s3;
      s5 <= s4;
    end
  end

  // output register
  logic [SUM_W-2*FRAC_BITS-1:0] whole;
  assign whole = sum5[SUM_W-1:2*FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s5.v && s5.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= s5.in_range;
      if (!s5.in_range) m_tdata <= '0;
      else if (whole > (SUM_W-2*FRAC_BITS)'(255)) m_tdata <= PIX_W'(255);
      else m_tdata <= PIX_W'(whole);
    end
  end

  a_base_clamped: assert property (@(posedge clk) disable iff (rst)
    (s2.v && s2.kind) |-> (h2 <= srm2 && w2 <= scm2))
    else $error("base index above size minus two");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    (s2.v && s2.kind && s2.in_range) |-> (u2 <= ONE && t2 <= ONE))
    else $error("fraction above one");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("out-of-range query with nonzero pixel");

endmodule

// ===== test/bilinear_upscaler_test.sv =====
// bilinear_upscaler_test: self-checking testbench for the bilinear upscaler.
// Depends on bu_pkg and bilinear_upscaler. It loads the source images, queries them
// across several size/scale settings, and checks each result against a directed value or its own model.
module bilinear_upscaler_test;
  import bu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_LOAD  = 0;
  localparam int KIND_QUERY = 1;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             rng;
  } pixel_res_t;

  typedef struct {
    bit              kind;
    int              row;
    int              col;
    int              pix;
    bit              chk;
    int              epix;
    bit              erng;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [PIX_W-1:0]     m_tdata;
  logic                 m_tuser;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bilinear_upscaler uut (.*);

  // scoreboard state
  logic [7:0]       img_mem [MAX_ROWS*MAX_COLS];
  int unsigned      cfg_rows, cfg_cols, cfg_scale;
  pixel_res_t       pending_pix[$];
  int               n_fail, n_queries, n_loads, n_results;
  int               idle_pct, stall_pct;

  dir_row_t dir_tab [18] = '{
    '{KIND_LOAD,  0, 0, 8'h00, 0, 0, 0},
    '{KIND_LOAD,  0, 1, 8'hFF, 0, 0, 0},
    '{KIND_LOAD,  1, 0, 8'hFF, 0, 0, 0},
    '{KIND_LOAD,  1, 1, 8'h00, 0, 0, 0},
    '{KIND_LOAD,  16383, 16383, 8'hAB, 0, 0, 0},
    '{KIND_LOAD,  255, 255, 8'h5A, 0, 0, 0},
    '{KIND_QUERY, 0, 0, 8'hFF, 1, 8'h00, 1},
    '{KIND_QUERY, 0, 1, 8'h00, 1, 8'hFF, 1},
    '{KIND_QUERY, 1, 0, 8'h00, 1, 8'hFF, 1},
    '{KIND_QUERY, 1, 1, 8'h00, 1, 8'h00, 1},
    '{KIND_QUERY, 2, 0, 8'h00, 1, 8'h00, 0},
    '{KIND_QUERY, 0, 2, 8'h00, 1, 8'h00, 0},
    '{KIND_QUERY, 16383, 16383, 8'h00, 1, 8'h00, 0},
    '{KIND_LOAD,  1, 1, 8'hFF, 0, 0, 0},
    '{KIND_QUERY, 1, 1, 8'h00, 1, 8'hFF, 1},
    '{KIND_LOAD,  0, 0, 8'hFF, 0, 0, 0},
    '{KIND_QUERY, 0, 0, 8'h00, 1, 8'hFF, 1},
    '{KIND_QUERY, 1, 0, 8'h00, 0, 0, 0}
  };

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned eff_scale();
    if (cfg_scale == 0) return 1;
    if (cfg_scale > MAX_SCALE) return MAX_SCALE;
    return cfg_scale;
  endfunction

  function automatic longint unsigned axis_pos(longint unsigned c, longint unsigned s,
                                               longint unsigned d);
    return ((c * (s - 1)) << FRAC_BITS) / (d - 1);
  endfunction

  function automatic longint unsigned px(longint unsigned r, longint unsigned c);
    return img_mem[r*MAX_COLS + c];
  endfunction

  function automatic pixel_res_t blend_pixel(int unsigned row, int unsigned col);
    longint unsigned sr, sc, dr, dc, pr, pc, h, w, u, t, one, sum;
    pixel_res_t res;
    sr = eff_size(cfg_rows, MAX_ROWS);
    sc = eff_size(cfg_cols, MAX_COLS);
    dr = sr * eff_scale();
    dc = sc * eff_scale();
    res = '0;
    if (row >= dr || col >= dc) return res;
    pr = axis_pos(row, sr, dr);
    pc = axis_pos(col, sc, dc);
    h = pr >> FRAC_BITS;
    if (h > sr - 2) h = sr - 2;
    w = pc >> FRAC_BITS;
    if (w > sc - 2) w = sc - 2;
    u = pr - (h << FRAC_BITS);
    t = pc - (w << FRAC_BITS);
    one = 64'd1 << FRAC_BITS;
    sum = px(h, w) * (one - t) * (one - u) + px(h, w + 1) * t * (one - u)
        + px(h + 1, w + 1) * t * u + px(h + 1, w) * (one - t) * u;
    sum = sum >> (2 * FRAC_BITS);
    if (sum > 255) sum = 255;
    res.pix = sum[7:0];
    res.rng = 1'b1;
    return res;
  endfunction

  // one transaction on s_; the model is updated at acceptance
  task automatic send_item(bit kind, int row, int col, int pix, bit chk = 0,
                           int epix = 0, bit erng = 0);
    pixel_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= IN_DATA_W'({pix[7:0], col[13:0], row[13:0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      n_loads++;
      if (row < MAX_ROWS && col < MAX_COLS) begin
        img_mem[row*MAX_COLS + col] = pix[7:0];
      end
    end else begin
      n_queries++;
      if (chk) begin
        res.pix = epix[7:0];
        res.rng = erng;
      end else
        res = blend_pixel(row, col);
      pending_pix.push_back(res);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ROWS:  cfg_rows  = val & 9'h1FF;
      REG_COLS:  cfg_cols  = val & 9'h1FF;
      REG_SCALE: cfg_scale = val & 7'h7F;
      default: ;
    endcase
  endtask

  // load every source pixel so each query's four neighbors are loaded, then mix random queries and loads
  task automatic random_phase(int n_items, bit mid_pause);
    int unsigned sr, sc, dr, dc, sel;
    sr = eff_size(cfg_rows, MAX_ROWS);
    sc = eff_size(cfg_cols, MAX_COLS);
    dr = sr * eff_scale();
    dc = sc * eff_scale();
    for (int r = 0; r < sr; r++)
      for (int c = 0; c < sc; c++)
        send_item(KIND_LOAD, r, c, $urandom_range(255));
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) drain();
      sel = $urandom_range(99);
      if (sel < 68)
        send_item(KIND_QUERY, $urandom_range(dr - 1), $urandom_range(dc - 1),
                  $urandom_range(255));
      else if (sel < 74)
        send_item(KIND_QUERY, dr - 1, $urandom_range(dc - 1), $urandom_range(255));
      else if (sel < 82)
        send_item(KIND_QUERY, $urandom_range(16383), $urandom_range(16383),
                  $urandom_range(255));
      else if (sel < 94)
        send_item(KIND_LOAD, $urandom_range(sr - 1), $urandom_range(sc - 1),
                  $urandom_range(255));
      else
        send_item(KIND_LOAD, $urandom_range(16383), $urandom_range(16383),
                  $urandom_range(255));
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected result pix=%0d in_range=%0b", $time, m_tdata, m_tuser);
        n_fail++;
      end else begin
        if (m_tdata !== pending_pix[0].pix || m_tuser !== pending_pix[0].rng) begin
          $display("%0t: mismatch expected pix=%0d in_range=%0b actual pix=%0d in_range=%0b",
                   $time, pending_pix[0].pix, pending_pix[0].rng, m_tdata, m_tuser);
          n_fail++;
        end
        void'(pending_pix.pop_front());
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 47; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 47; end
      default: begin idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  initial begin
    int unsigned ph [7][3] = '{
      '{2, 40, 64}, '{9, 3, 511}, '{0, 1, 0}, '{5, 7, 2},
      '{6, 6, 5}, '{3, 4, 9}, '{4, 5, 1}
    };
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_ROWS; cfg_data = '0;
    cfg_rows = 256; cfg_cols = 256; cfg_scale = 1;
    n_fail = 0; n_queries = 0; n_loads = 0; n_results = 0;
    set_mode(0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_ROWS, 2);
    write_reg(REG_COLS, 2);
    write_reg(REG_SCALE, 1);
    foreach (dir_tab[i])
      send_item(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].pix,
                dir_tab[i].chk, dir_tab[i].epix, dir_tab[i].erng);
    drain();

    for (int p = 0; p < 7; p++) begin
      set_mode(p);
      write_reg(REG_ROWS, ph[p][0]);
      write_reg(REG_COLS, ph[p][1]);
      write_reg(REG_SCALE, ph[p][2]);
      random_phase(60, p == 2);
    end

    $display("Covered %0d loads and %0d queries over 8 size/scale settings,",
             n_loads, n_queries);
    $display("with %0d results checked under mixed idle and stall patterns.", n_results);
    if (n_fail == 0 && pending_pix.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bu_pkg.sv
rtl/core/bu_ram.sv
rtl/core/bu_divider.sv
rtl/core/bu_blend.sv
rtl/core/bilinear_upscaler.sv
test/bilinear_upscaler_test.sv
